[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, codes and the entry and command types of the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned TAG_W        = 8;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // one slot of the queue
  typedef struct packed {
    logic                     occ;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot: keeps, takes the new job, or shifts from a neighbour each cycle.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_cmd_t cmd_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_stay_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output logic               stay_o
);

  spq_pkg::entry_t cur_r;
  spq_pkg::entry_t cur_nxt;
  logic            stay;

  // entry is ahead of the new job (ties keep arrival order)
  assign stay = cur_r.occ && ($signed(cur_r.prio) >= $signed(cmd_i.prio));

  always_comb begin
    cur_nxt = cur_r;
    if (cmd_i.enq) begin
      if (!stay) begin
        if (left_stay_i) begin
          cur_nxt.occ  = 1'b1;
          cur_nxt.tag  = cmd_i.tag;
          cur_nxt.prio = cmd_i.prio;
        end else begin
          cur_nxt = left_i;
        end
      end
    end else if (cmd_i.deq) begin
      cur_nxt = right_i;
    end
  end

  // only the occupied flag is reset; tag and priority are don't-care until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.occ <= 1'b0;
    end else begin
      cur_r.occ <= cur_nxt.occ;
    end
    cur_r.tag  <= cur_nxt.tag;
    cur_r.prio <= cur_nxt.prio;
  end

  assign entry_o = cur_r;
  assign stay_o  = stay;

endmodule

[sv/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of tagged jobs, held in descending signed priority order.
// ----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells, front at cell 0. Every cell compares
// its own priority with the incoming job in parallel, so an enqueue or a
// dequeue finishes in the cycle of its transfer: one item can be
// accepted every clock, and its result is registered and offered on the out_
// channel from the next cycle. The input stalls only while a result is held
// back by out_ready. Equal priorities leave in arrival order. A dequeue on an
// empty queue reports underflow; an enqueue on a full queue is dropped and
// reports overflow. Occupancy is the count after the item, modulo 32. The
// throughput is set by the cell row's compare-and-shift, one per cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [spq_pkg::TAG_W-1:0]         in_job_tag,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_job_priority,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_removed_valid,
  output logic [spq_pkg::TAG_W-1:0]         out_removed_tag,
  output logic signed [spq_pkg::PRIO_W-1:0] out_removed_priority,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // input side
  logic               in_xfer;
  logic               is_enq;
  logic               is_deq;
  logic               full;
  logic               empty;
  logic               enq_ok;
  logic               deq_ok;
  spq_pkg::cell_cmd_t cmd;

  // entry count
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // cell row wiring
  spq_pkg::entry_t    cell_q [CAPACITY];
  logic               cell_stay [CAPACITY];

  // result register
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  spq_pkg::status_t                  status_r;
  spq_pkg::status_t                  status_nxt;
  logic                              rm_valid_r;
  logic                              rm_valid_nxt;
  logic [spq_pkg::TAG_W-1:0]         rm_tag_r;
  logic [spq_pkg::TAG_W-1:0]         rm_tag_nxt;
  logic signed [spq_pkg::PRIO_W-1:0] rm_prio_r;
  logic signed [spq_pkg::PRIO_W-1:0] rm_prio_nxt;
  logic [spq_pkg::OCC_W-1:0]         occ_r;
  logic [spq_pkg::OCC_W-1:0]         occ_nxt;

  // --------------------------------------------------------------------------
  // Handshake and command decode
  // --------------------------------------------------------------------------
  // a held result frees its register on the same edge it is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign is_enq = (in_opcode == spq_pkg::OP_ENQ);
  assign is_deq = (in_opcode == spq_pkg::OP_DEQ);
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign enq_ok = in_xfer && is_enq && !full;
  assign deq_ok = in_xfer && is_deq && !empty;

  assign cmd.enq  = enq_ok;
  assign cmd.deq  = deq_ok;
  assign cmd.tag  = in_job_tag;
  assign cmd.prio = in_job_priority;

  // --------------------------------------------------------------------------
  // Cell row: cell 0 is the front. Insert takes the first cell that is not
  // ahead of the new job; cells behind it shift one place towards the tail.
  // Dequeue shifts every cell one place towards the front.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_w;
    spq_pkg::entry_t right_w;
    logic            left_stay_w;

    if (i == 0) begin : g_front
      assign left_w      = '0;
      assign left_stay_w = 1'b1;
    end else begin : g_mid_l
      assign left_w      = cell_q[i-1];
      assign left_stay_w = cell_stay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd_i       (cmd),
      .left_i      (left_w),
      .left_stay_i (left_stay_w),
      .right_i     (right_w),
      .entry_o     (cell_q[i]),
      .stay_o      (cell_stay[i])
    );
  end

  // --------------------------------------------------------------------------
  // Count and result
  // --------------------------------------------------------------------------
  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (deq_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    status_nxt   = spq_pkg::ST_OK;
    rm_valid_nxt = 1'b0;
    rm_tag_nxt   = '0;
    rm_prio_nxt  = '0;
    if (is_enq && full) begin
      status_nxt = spq_pkg::ST_OVER;
    end else if (is_deq && empty) begin
      status_nxt = spq_pkg::ST_UNDER;
    end else if (is_deq) begin
      rm_valid_nxt = 1'b1;
      rm_tag_nxt   = cell_q[0].tag;
      rm_prio_nxt  = cell_q[0].prio;
    end
    occ_nxt = spq_pkg::OCC_W'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r   <= status_nxt;
      rm_valid_r <= rm_valid_nxt;
      rm_tag_r   <= rm_tag_nxt;
      rm_prio_r  <= rm_prio_nxt;
      occ_r      <= occ_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_removed_valid    = rm_valid_r;
  assign out_removed_tag      = rm_tag_r;
  assign out_removed_priority = rm_prio_r;
  assign out_occupancy        = occ_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // front cell is occupied exactly when the count is non-zero
  a_front_occ : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == cell_q[0].occ)
    else $error("front cell occupancy disagrees with count");

  // count never exceeds the row length
  a_count_max : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a successful insert grows the queue by one
  a_enq_grow : assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the queue");

  // removed entry only reported with ok status
  a_rm_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rm_valid_r) |-> (status_r == spq_pkg::ST_OK))
    else $error("removed entry with error status");
`endif

endmodule
